// ===== sv/particle_kinematic_integrator_assert.svh =====
// Assertion macros shared by the checker files of the particle integrator.
// No dependencies; include by bare file name.
`ifndef PARTICLE_KINEMATIC_INTEGRATOR_ASSERT_SVH
`define PARTICLE_KINEMATIC_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PKI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PKI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pki_pkg.sv =====
// Shared types, register indexes and fixed-point helpers of the particle integrator.
// No dependencies.
package pki_pkg;

  localparam int AXES      = 3;
  localparam int AXIS_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int DT_W      = 17;
  localparam int FRIC_W    = 17;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 192;

  localparam logic [CFG_IDX_W-1:0] REG_FORCE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS = 3'd6;

  localparam logic [FRIC_W-1:0] FRIC_NONE     = 17'd65536;
  localparam logic [31:0]       INV_MASS_ONE  = 32'd65536;
  localparam logic [AXIS_W-1:0] AXIS_LAST     = 2'd2;

  // Datapath operation; each multiply op is followed by its write-back.
  typedef enum logic [2:0] {
    OP_ADD,  // net = sat(net + force)
    OP_NF,   // net = sat(net * friction >> 16)
    OP_AC,   // acc = sat(net * inverse_mass >> 16)
    OP_AD,   // adt = acc * dt >> 16
    OP_VD,   // vdt = vel * dt >> 16
    OP_AA,   // pos = sat(pos + vdt + adt * dt >> 17)
    OP_VF    // vel = sat((vel + adt) * friction >> 16)
  } pki_op_t;

  typedef struct packed {
    logic          load_dt;
    logic          mul_en;
    logic          wb_en;
    logic          capture;
    pki_op_t       op;
    logic [AXIS_W-1:0] axis;
  } pki_cmd_t;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
    logic signed [31:0] r;
    if (x > 51'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/pki_datapath.sv =====
// Datapath of the particle integrator: config registers, per-axis state,
// one shared signed multiplier with a registered product, output register.
// Depends on pki_pkg.
module pki_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pki_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [pki_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic [pki_pkg::DT_W-1:0]      time_step,
  input  pki_pkg::pki_cmd_t             cmd,
  output logic [pki_pkg::OUT_TDATA_W-1:0] out_data
);
  import pki_pkg::*;

  logic signed [31:0]       force_r [AXES];
  logic [FRIC_W-1:0]        fric_r  [AXES];
  logic [31:0]              inv_mass_r;
  logic signed [31:0]       net_r   [AXES];
  logic signed [31:0]       vel_r   [AXES];
  logic signed [31:0]       pos_r   [AXES];

  logic [DT_W-1:0]          dt_r;
  logic signed [31:0]       net_w_r;
  logic signed [31:0]       acc_r;
  logic signed [32:0]       adt_r;
  logic signed [32:0]       vdt_r;
  logic signed [66:0]       prod_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  logic signed [33:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [31:0]       cur_force;
  logic [FRIC_W-1:0]        cur_fric;
  logic signed [31:0]       cur_net;
  logic signed [31:0]       cur_vel;
  logic signed [31:0]       cur_pos;
  logic signed [50:0]       prod_sh16;
  logic signed [50:0]       add_sum;
  logic signed [50:0]       pos_sum;
  logic signed [31:0]       sat_prod;
  logic signed [31:0]       sat_add;
  logic signed [31:0]       sat_pos;

  assign cur_force = force_r[cmd.axis];
  assign cur_fric  = fric_r[cmd.axis];
  assign cur_net   = net_r[cmd.axis];
  assign cur_vel   = vel_r[cmd.axis];
  assign cur_pos   = pos_r[cmd.axis];

  // Floor shifts are plain part-selects of the two's complement product.
  assign prod_sh16 = prod_r[66:16];
  assign add_sum   = {{19{cur_net[31]}}, cur_net} + {{19{cur_force[31]}}, cur_force};
  assign pos_sum   = {{19{cur_pos[31]}}, cur_pos} + {{18{vdt_r[32]}}, vdt_r}
                   + {{18{prod_r[66]}}, prod_r[49:17]};
  assign sat_prod  = sat32(prod_sh16);
  assign sat_add   = sat32(add_sum);
  assign sat_pos   = sat32(pos_sum);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_NF: begin
        mul_a = {{2{net_w_r[31]}}, net_w_r};
        mul_b = {16'd0, cur_fric};
      end
      OP_AC: begin
        mul_a = {{2{net_w_r[31]}}, net_w_r};
        mul_b = {1'b0, inv_mass_r};
      end
      OP_AD: begin
        mul_a = {{2{acc_r[31]}}, acc_r};
        mul_b = {16'd0, dt_r};
      end
      OP_VD: begin
        mul_a = {{2{cur_vel[31]}}, cur_vel};
        mul_b = {16'd0, dt_r};
      end
      OP_AA: begin
        mul_a = {adt_r[32], adt_r};
        mul_b = {16'd0, dt_r};
      end
      OP_VF: begin
        mul_a = {{2{cur_vel[31]}}, cur_vel} + {adt_r[32], adt_r};
        mul_b = {16'd0, cur_fric};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration and per-axis state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        force_r[i] <= '0;
        fric_r[i]  <= FRIC_NONE;
        net_r[i]   <= '0;
        vel_r[i]   <= '0;
        pos_r[i]   <= '0;
      end
      inv_mass_r <= INV_MASS_ONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_FORCE_X:  force_r[0] <= cfg_wdata;
          REG_FORCE_Y:  force_r[1] <= cfg_wdata;
          REG_FORCE_Z:  force_r[2] <= cfg_wdata;
          REG_FRIC_X:   fric_r[0]  <= cfg_wdata[FRIC_W-1:0];
          REG_FRIC_Y:   fric_r[1]  <= cfg_wdata[FRIC_W-1:0];
          REG_FRIC_Z:   fric_r[2]  <= cfg_wdata[FRIC_W-1:0];
          REG_INV_MASS: inv_mass_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.wb_en) begin
        unique case (cmd.op)
          OP_NF:   net_r[cmd.axis] <= sat_prod;
          OP_AA:   pos_r[cmd.axis] <= sat_pos;
          OP_VF:   vel_r[cmd.axis] <= sat_prod;
          default: ;
        endcase
      end
    end
  end

  // Working registers, product and output register.
  always_ff @(posedge clk) begin
    if (cmd.load_dt) begin
      dt_r <= time_step;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.wb_en) begin
      unique case (cmd.op)
        OP_ADD:  net_w_r <= sat_add;
        OP_NF:   net_w_r <= sat_prod;
        OP_AC:   acc_r   <= sat_prod;
        OP_AD:   adt_r   <= prod_r[48:16];
        OP_VD:   vdt_r   <= prod_r[48:16];
        default: ;
      endcase
    end
    if (cmd.capture) begin
      out_data_r <= {vel_r[2], vel_r[1], vel_r[0], pos_r[2], pos_r[1], pos_r[0]};
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== sv/pki_ctrl.sv =====
// Sequencer of the particle integrator: walks the three axes through the
// add, multiply and write-back steps and runs the result handshake.
// Depends on pki_pkg.
module pki_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pki_pkg::pki_cmd_t cmd
);
  import pki_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_t;

  state_t            state_r;
  pki_op_t           op_r;
  logic [AXIS_W-1:0] axis_r;
  logic              out_valid_r;
  logic              can_load;
  pki_op_t           op_next;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    unique case (op_r)
      OP_ADD:  op_next = OP_NF;
      OP_NF:   op_next = OP_AC;
      OP_AC:   op_next = OP_AD;
      OP_AD:   op_next = OP_VD;
      OP_VD:   op_next = OP_AA;
      OP_AA:   op_next = OP_VF;
      default: op_next = OP_ADD;
    endcase
  end

  always_comb begin
    cmd.load_dt = (state_r == ST_IDLE) && in_valid;
    cmd.mul_en  = (state_r == ST_MUL);
    cmd.wb_en   = (state_r == ST_WB) || (state_r == ST_ADD);
    cmd.capture = (state_r == ST_DONE) && can_load;
    cmd.op      = (state_r == ST_ADD) ? OP_ADD : op_r;
    cmd.axis    = axis_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_ADD;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A fresh result may replace the one leaving in the same cycle.
      if (cmd.capture) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            axis_r  <= '0;
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          op_r    <= OP_NF;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_WB;
        end
        ST_WB: begin
          if (op_r == OP_VF) begin
            if (axis_r == AXIS_LAST) begin
              state_r <= ST_DONE;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= ST_ADD;
            end
          end else begin
            op_r    <= op_next;
            state_r <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (can_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/particle_kinematic_integrator.sv =====
// Three-axis constant-acceleration particle integrator, fixed point.
// Each input beat carries one time step dt (Q1.16, 17 bits in in_tdata[16:0]).
// Per axis the stored net force gains the applied force and is scaled by
// friction; acceleration is net force times inverse mass; position advances
// by v*dt + a*dt*dt/2 and velocity becomes (v + a*dt) * friction.
// Each input beat gives one output beat with the new positions and velocities
// (Q16.16, saturated), pos_x in the lowest 32 bits of out_tdata.
// Items are worked one at a time: a new input is taken only when idle, after
// the result is loaded into the output register. The single shared multiplier
// sets the order of steps: per axis one add step, then six products, each a
// multiply step followed by its write-back step.
// The finished result sits in an output register; the next input is accepted
// while it waits. If the receiver stalls beyond the next item's computation,
// the sequencer holds that item until the output register frees.
// Write registers through cfg_we/cfg_addr/cfg_wdata only while idle; the block
// does not enforce this. An unknown index is ignored. Reset (rst_n low, synchronous)
// clears force, velocity and position, sets friction to none and inverse mass to one.
// Depends on pki_pkg, pki_ctrl and pki_datapath.
module particle_kinematic_integrator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pki_pkg::IN_TDATA_W-1:0]    in_tdata,   // [16:0] time_step, rest zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
  // [127:96] vel_x, [159:128] vel_y, [191:160] vel_z
  output logic [pki_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [pki_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pki_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import pki_pkg::*;

  pki_cmd_t cmd;

  pki_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  pki_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .time_step (in_tdata[DT_W-1:0]),
    .cmd       (cmd),
    .out_data  (out_tdata)
  );

endmodule

// ===== sv/pki_checker.sv =====
// Port-level checks of the particle integrator, bound to the top level.
// Depends on pki_pkg and particle_kinematic_integrator_assert.svh.
`include "particle_kinematic_integrator_assert.svh"

module pki_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pki_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pki_pkg::*;

  logic in_beat;
  logic out_stall;

  assign in_beat   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  // A stalled output beat keeps its valid and its payload.
  `PKI_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid, "output valid dropped while stalled")
  `PKI_ASSERT_NXT(a_out_data, clk, rst_n, out_stall, $stable(out_tdata), "output data changed while stalled")
  // One item is worked at a time, so the input closes right after a beat.
  `PKI_ASSERT_NXT(a_one_item, clk, rst_n, in_beat, !in_tready, "input accepted during computation")
  // The result is computed first; no output beat rises right after an input beat.
  `PKI_ASSERT_NXT(a_no_early, clk, rst_n, in_beat, !$rose(out_tvalid), "result appeared too early")

endmodule

bind particle_kinematic_integrator pki_checker u_pki_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/tb.sv =====
// Self-checking testbench for particle_kinematic_integrator: drives time steps over the
// input stream, predicts position and velocity per axis in fixed point and checks every
// result beat. Depends on pki_pkg and the integrator RTL.
`timescale 1ns / 100ps

module tb;
  import pki_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRESS_NONE = 0;
  localparam int PRESS_RX_HOLD = 1;
  localparam int PRESS_TX_PAUSE = 2;

  // Same layout as out_tdata: pos_x in the lowest bits, vel_z in the highest.
  typedef struct packed {
    logic [AXES-1:0][31:0] vel;
    logic [AXES-1:0][31:0] pos;
  } kin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  particle_kinematic_integrator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Register copies and integrator state of the predictor.
  logic signed [31:0] force_q [AXES] = '{0, 0, 0};
  logic [FRIC_W-1:0] fric_q [AXES] = '{FRIC_NONE, FRIC_NONE, FRIC_NONE};
  logic [31:0] inv_mass_q = INV_MASS_ONE;
  longint net_q [AXES] = '{0, 0, 0};
  longint vel_q [AXES] = '{0, 0, 0};
  longint pos_q [AXES] = '{0, 0, 0};

  logic [DT_W-1:0] dt_pending [$];
  kin_result_t kin_expect [$];
  string axis_name [AXES] = '{"x", "y", "z"};

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit tx_pause = 1'b0;
  int rx_hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_q16(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // One integration step on all three axes; every shift floors.
  function automatic kin_result_t advance_particle(input logic [DT_W-1:0] dt);
    kin_result_t r;
    longint t, fr, net, acc, adt, p, v;
    int a;
    t = longint'(dt);
    for (a = 0; a < AXES; a++) begin
      fr = longint'(fric_q[a]);
      net = clamp_q16(net_q[a] + longint'(force_q[a]));
      net = clamp_q16((net * fr) >>> 16);
      net_q[a] = net;
      acc = clamp_q16((net * longint'(inv_mass_q)) >>> 16);
      adt = (acc * t) >>> 16;
      v = vel_q[a];
      p = clamp_q16(pos_q[a] + ((v * t) >>> 16) + ((adt * t) >>> 17));
      v = clamp_q16(((v + adt) * fr) >>> 16);
      pos_q[a] = p;
      vel_q[a] = v;
      r.pos[a] = p[31:0];
      r.vel[a] = v[31:0];
    end
    return r;
  endfunction

  // Driver: offers queued time steps and records the expected motion on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        kin_expect.push_back(advance_particle(in_tdata[DT_W-1:0]));
      end
      if (!in_tvalid || in_tready) begin
        if (dt_pending.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'(dt_pending.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, long hold-offs on request, and result checking.
  always @(posedge clk) begin
    kin_result_t want, got;
    int a;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
      if (out_tvalid && out_tready) begin
        got = kin_result_t'(out_tdata);
        if (kin_expect.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none, got %h", $time, out_tdata);
        end else begin
          want = kin_expect.pop_front();
          for (a = 0; a < AXES; a++) begin
            if (got.pos[a] !== want.pos[a]) begin
              mismatches++;
              $display("%0t: pos_%s expected %0d got %0d", $time, axis_name[a],
                       $signed(want.pos[a]), $signed(got.pos[a]));
            end
            if (got.vel[a] !== want.vel[a]) begin
              mismatches++;
              $display("%0t: vel_%s expected %0d got %0d", $time, axis_name[a],
                       $signed(want.vel[a]), $signed(got.vel[a]));
            end
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no beat and no register write has happened for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_FORCE_X:  force_q[0] = value;
      REG_FORCE_Y:  force_q[1] = value;
      REG_FORCE_Z:  force_q[2] = value;
      REG_FRIC_X:   fric_q[0] = value[FRIC_W-1:0];
      REG_FRIC_Y:   fric_q[1] = value[FRIC_W-1:0];
      REG_FRIC_Z:   fric_q[2] = value[FRIC_W-1:0];
      REG_INV_MASS: inv_mass_q = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (dt_pending.size() != 0 || in_tvalid || kin_expect.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [DT_W-1:0] random_dt();
    case ($urandom_range(9))
      0: return '0;
      1: return DT_W'(65536);
      2: return '1;
      3, 4: return DT_W'($urandom_range(1, 2000));
      5, 6: return DT_W'($urandom_range(0, 65535));
      default: return DT_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [31:0] pick_fric();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'h0001ffff;
      default: return $urandom;
    endcase
  endfunction

  // Modes: gentle damped motion, full-range noise, extreme corners, free coasting.
  task automatic configure_mode(input int mode);
    int a;
    int f;
    for (a = 0; a < AXES; a++) begin
      case (mode)
        0: begin
          f = $urandom_range(0, 524288) - 262144;
          write_reg(CFG_IDX_W'(REG_FORCE_X + a), 32'(f));
          write_reg(CFG_IDX_W'(REG_FRIC_X + a), $urandom_range(61000, 65536));
        end
        1: begin
          write_reg(CFG_IDX_W'(REG_FORCE_X + a), $urandom);
          write_reg(CFG_IDX_W'(REG_FRIC_X + a), $urandom);
        end
        2: begin
          f = $urandom_range(0, 131072) - 65536;
          write_reg(CFG_IDX_W'(REG_FORCE_X + a), 32'(f));
          write_reg(CFG_IDX_W'(REG_FRIC_X + a), pick_fric());
        end
        default: begin
          write_reg(CFG_IDX_W'(REG_FORCE_X + a), 32'd0);
          write_reg(CFG_IDX_W'(REG_FRIC_X + a), 32'(FRIC_NONE));
        end
      endcase
    end
    case (mode)
      0: write_reg(REG_INV_MASS, $urandom_range(16384, 131072));
      1: write_reg(REG_INV_MASS, $urandom);
      2: begin
        case ($urandom_range(2))
          0: write_reg(REG_INV_MASS, 32'd0);
          1: write_reg(REG_INV_MASS, 32'd1);
          default: write_reg(REG_INV_MASS, 32'hffffffff);
        endcase
      end
      default: begin
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_INV_MASS, INV_MASS_ONE);
      end
    endcase
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                           input int pressure);
    int k;
    @(negedge clk);
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    for (k = 0; k < count; k++) dt_pending.push_back(random_dt());
    if (pressure != PRESS_NONE) begin
      while (dt_pending.size() > count / 2) @(negedge clk);
      if (pressure == PRESS_RX_HOLD) begin
        rx_hold_left = 300;
      end else begin
        // Hold the sender back until every outstanding result is out.
        tx_pause = 1'b1;
        do @(negedge clk);
        while (in_tvalid || kin_expect.size() != 0);
        tx_pause = 1'b0;
      end
    end
    wait_drained();
  endtask

  initial begin
    int p;
    int send_idle [4];
    int recv_stall [4];
    send_idle = '{0, 84, 0, 31};
    recv_stall = '{0, 0, 84, 31};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: time step extremes at reset settings.
    dt_pending.push_back('0);
    dt_pending.push_back('1);
    wait_drained();

    // Force extremes, an unknown index, and zero inverse mass.
    write_reg(REG_UNUSED, 32'hdeadbeef);
    write_reg(REG_FORCE_X, 32'h7fffffff);
    write_reg(REG_FORCE_Y, 32'h80000000);
    write_reg(REG_FORCE_Z, 32'd12345);
    write_reg(REG_INV_MASS, 32'd0);
    dt_pending.push_back(DT_W'(65536));
    dt_pending.push_back('1);
    wait_drained();

    // Largest inverse mass, friction above one, zero friction and just below one.
    write_reg(REG_INV_MASS, 32'hffffffff);
    write_reg(REG_FRIC_X, 32'hffffffff);
    write_reg(REG_FRIC_Y, 32'd0);
    write_reg(REG_FRIC_Z, 32'd65535);
    dt_pending.push_back(DT_W'(65536));
    dt_pending.push_back(DT_W'(1));
    dt_pending.push_back('1);
    dt_pending.push_back(DT_W'(32768));
    wait_drained();

    // Reversed forces with all friction at zero, which clears net force and velocity.
    write_reg(REG_FORCE_X, 32'h80000000);
    write_reg(REG_FORCE_Y, 32'h7fffffff);
    write_reg(REG_FORCE_Z, 32'hffff0000);
    write_reg(REG_FRIC_X, 32'd0);
    write_reg(REG_FRIC_Y, 32'd0);
    write_reg(REG_FRIC_Z, 32'd0);
    dt_pending.push_back(DT_W'(1));
    dt_pending.push_back(DT_W'(65535));
    dt_pending.push_back('1);
    wait_drained();

    for (p = 0; p < 8; p++) begin
      configure_mode((p * 3) % 4);
      run_phase(130, send_idle[p % 4], recv_stall[p % 4],
                (p == 0) ? PRESS_RX_HOLD : (p == 1 || p == 5) ? PRESS_TX_PAUSE : PRESS_NONE);
    end

    repeat (50) @(posedge clk);
    if (kin_expect.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, kin_expect.size());
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
